/* design/lssr_pkg.sv */
// ----------------------------------------------------------------------------
// lssr_pkg
// Shared types and constants for the limited setpoint slew ramp.
// ----------------------------------------------------------------------------
package lssr_pkg;

  // enable bit positions within command_flags
  localparam int unsigned TV_ENABLE_BIT    = 0;
  localparam int unsigned REGEN_ENABLE_BIT = 1;

  // whole-percent step from the tenths accumulator
  localparam logic [3:0] TENTHS_PER_PCT = 4'd10;
  localparam logic [7:0] DIV10_MUL      = 8'd205;
  localparam int unsigned DIV10_SHIFT   = 11;

  // register indexes
  localparam logic [2:0] REG_TV_LIMIT        = 3'd0;
  localparam logic [2:0] REG_REGEN_LIMIT     = 3'd1;
  localparam logic [2:0] REG_TV_RAMP_RATE    = 3'd2;
  localparam logic [2:0] REG_TV_PERMITTED    = 3'd3;
  localparam logic [2:0] REG_REGEN_PERMITTED = 3'd4;

  // register reset values
  localparam logic [6:0] TV_LIMIT_RST        = 7'd100;
  localparam logic [6:0] REGEN_LIMIT_RST     = 7'd0;
  localparam logic [7:0] TV_RAMP_RATE_RST    = 8'd20;
  localparam logic       TV_PERMITTED_RST    = 1'b1;
  localparam logic       REGEN_PERMITTED_RST = 1'b0;

  typedef struct packed {
    logic       link_fresh;
    logic [7:0] tv_request;
    logic [7:0] regen_request;
    logic [7:0] command_flags;
    logic [7:0] drive_mode_in;
  } in_item_t;

  typedef struct packed {
    logic [6:0] tv_applied_out;
    logic [6:0] regen_out;
    logic [7:0] drive_mode_out;
    logic [7:0] flags_out;
    logic       fresh_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [6:0] tv_limit;
    logic [6:0] regen_limit;
    logic [7:0] tv_ramp_rate;
    logic       tv_permitted;
    logic       regen_permitted;
  } cfg_regs_t;

  typedef struct packed {
    logic [6:0] level;
    logic [3:0] remainder;
    logic [7:0] held_mode;
  } ramp_state_t;

endpackage

/* design/lssr_chan_if.sv */
// ----------------------------------------------------------------------------
// lssr_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lssr_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/lssr_ramp_core.sv */
// ----------------------------------------------------------------------------
// lssr_ramp_core
// Target selection, tenths accumulator and clamped ramp step for one tick.
// ----------------------------------------------------------------------------
module lssr_ramp_core (
  input  lssr_pkg::cfg_regs_t   cfg,
  input  lssr_pkg::in_item_t    item,
  input  lssr_pkg::ramp_state_t state_cur,
  output lssr_pkg::ramp_state_t state_nxt,
  output logic [6:0]            target,
  output lssr_pkg::out_item_t   result
);

  logic        tv_en;
  logic        regen_en;
  logic [6:0]  tv_cap;
  logic [6:0]  regen_cap;
  logic [6:0]  regen_val;
  logic [8:0]  acc;
  logic [16:0] acc_mul;
  logic [4:0]  step;
  logic [8:0]  acc_rem;
  logic [7:0]  up_sum;
  logic [6:0]  dn_diff;
  logic [6:0]  level_nxt;

  assign tv_en    = item.link_fresh && cfg.tv_permitted &&
                    item.command_flags[lssr_pkg::TV_ENABLE_BIT];
  assign regen_en = item.link_fresh && cfg.regen_permitted &&
                    item.command_flags[lssr_pkg::REGEN_ENABLE_BIT];

  assign tv_cap    = (item.tv_request < {1'b0, cfg.tv_limit}) ?
                     item.tv_request[6:0] : cfg.tv_limit;
  assign regen_cap = (item.regen_request < {1'b0, cfg.regen_limit}) ?
                     item.regen_request[6:0] : cfg.regen_limit;

  assign target    = tv_en ? tv_cap : 7'd0;
  assign regen_val = regen_en ? regen_cap : 7'd0;

  // divide by ten via reciprocal, exact for acc below 1029
  assign acc     = {5'd0, state_cur.remainder} + {1'b0, cfg.tv_ramp_rate};
  assign acc_mul = 17'(acc) * 17'(lssr_pkg::DIV10_MUL);
  assign step    = acc_mul[lssr_pkg::DIV10_SHIFT +: 5];
  assign acc_rem = acc - 9'(step) * 9'(lssr_pkg::TENTHS_PER_PCT);

  assign up_sum  = {1'b0, state_cur.level} + {3'd0, step};
  assign dn_diff = state_cur.level - target;

  always_comb begin
    level_nxt = state_cur.level;
    if (state_cur.level < target) begin
      level_nxt = (up_sum > {1'b0, target}) ? target : up_sum[6:0];
    end else if (state_cur.level > target) begin
      level_nxt = (dn_diff <= {2'd0, step}) ? target : state_cur.level - {2'd0, step};
    end
  end

  always_comb begin
    state_nxt.level     = level_nxt;
    state_nxt.remainder = acc_rem[3:0];
    state_nxt.held_mode = item.link_fresh ? item.drive_mode_in : state_cur.held_mode;
  end

  always_comb begin
    result.tv_applied_out = level_nxt;
    result.regen_out      = regen_val;
    result.drive_mode_out = state_nxt.held_mode;
    result.flags_out      = item.link_fresh ? item.command_flags : 8'd0;
    result.fresh_out      = item.link_fresh;
  end

endmodule

/* design/limited_setpoint_slew_ramp.sv */
// ----------------------------------------------------------------------------
// limited_setpoint_slew_ramp
// Per-tick torque vectoring slew limiter with bounded regen pass-through.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while input ready is high: the item
// is captured in an input register, then a single pass through the ramp logic
// (target cap, divide-by-ten of the tenths accumulator, clamped step) updates
// the ramp state and the result register together, so each item sees the state
// left by the one before it. The result register frees its stage as soon as
// the item is taken, and input ready drops only while both stages hold items
// and the output is stalled. Configuration writes are always ready; indexes
// beyond the five registers are ignored.
module limited_setpoint_slew_ramp (
  input  logic              clk,
  input  logic              rst_n,
  lssr_chan_if.sink         in_chan,
  lssr_chan_if.source       out_chan,
  lssr_chan_if.sink         cfg_chan
);

  logic                  s1_vld_r;
  lssr_pkg::in_item_t    s1_item_r;
  logic                  out_vld_r;
  lssr_pkg::out_item_t   out_item_r;
  lssr_pkg::ramp_state_t ramp_st_r;
  lssr_pkg::ramp_state_t ramp_st_nxt;
  lssr_pkg::cfg_regs_t   cfg_r;
  lssr_pkg::out_item_t   result;
  lssr_pkg::cfg_item_t   cfg_wr;
  logic [6:0]            target;
  logic                  out_adv;
  logic                  s1_adv;
  logic                  in_ready;
  logic                  in_fire;

  assign out_adv  = !out_vld_r || out_chan.ready;
  assign s1_adv   = s1_vld_r && out_adv;
  assign in_ready = !s1_vld_r || out_adv;
  assign in_fire  = in_chan.valid && in_ready;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_item_r;
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.data;

  lssr_ramp_core u_core (
    .cfg       (cfg_r),
    .item      (s1_item_r),
    .state_cur (ramp_st_r),
    .state_nxt (ramp_st_nxt),
    .target    (target),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r                  <= 1'b0;
      out_vld_r                 <= 1'b0;
      ramp_st_r                 <= '0;
      cfg_r.tv_limit            <= lssr_pkg::TV_LIMIT_RST;
      cfg_r.regen_limit         <= lssr_pkg::REGEN_LIMIT_RST;
      cfg_r.tv_ramp_rate        <= lssr_pkg::TV_RAMP_RATE_RST;
      cfg_r.tv_permitted        <= lssr_pkg::TV_PERMITTED_RST;
      cfg_r.regen_permitted     <= lssr_pkg::REGEN_PERMITTED_RST;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (out_adv) begin
        out_vld_r <= s1_vld_r;
      end
      if (s1_adv) begin
        ramp_st_r <= ramp_st_nxt;
      end
      if (cfg_chan.valid) begin
        case (cfg_wr.index)
          lssr_pkg::REG_TV_LIMIT:        cfg_r.tv_limit        <= cfg_wr.value[6:0];
          lssr_pkg::REG_REGEN_LIMIT:     cfg_r.regen_limit     <= cfg_wr.value[6:0];
          lssr_pkg::REG_TV_RAMP_RATE:    cfg_r.tv_ramp_rate    <= cfg_wr.value;
          lssr_pkg::REG_TV_PERMITTED:    cfg_r.tv_permitted    <= cfg_wr.value[0];
          lssr_pkg::REG_REGEN_PERMITTED: cfg_r.regen_permitted <= cfg_wr.value[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_chan.data;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  // remainder of the tenths accumulator stays below ten
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_st_r.remainder < lssr_pkg::TENTHS_PER_PCT)
    else $error("ramp remainder out of range");

  // rising ramp never passes its target
  a_no_overshoot_up: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (ramp_st_r.level < target) |=>
      (ramp_st_r.level <= $past(target)) && (ramp_st_r.level >= $past(ramp_st_r.level)))
    else $error("ramp overshoot rising");

  // falling ramp never passes its target
  a_no_overshoot_dn: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (ramp_st_r.level > target) |=>
      (ramp_st_r.level >= $past(target)) && (ramp_st_r.level <= $past(ramp_st_r.level)))
    else $error("ramp overshoot falling");

  // input stalls only when both stages are full and the output is held
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_vld_r && out_vld_r && !out_chan.ready)
    else $error("input stalled without cause");

  // stale tick gives zero flags and zero regen
  a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_item_r.link_fresh |=>
      (out_item_r.flags_out == 8'd0) && (out_item_r.regen_out == 7'd0))
    else $error("stale item with nonzero request");

endmodule
